// ===== sv/dcsrp_pkg.sv =====
// Shared types and constants for the dual channel serial register port.
// Used by the configuration block, the channel core and the top level.
package dcsrp_pkg;

	// Control reads return status only when pointer modulo this count is zero
	localparam int StatusRegCount = 3;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 24;

	localparam logic [2:0] CMD_CHANNEL_RESET = 3'd3;
	localparam logic [7:0] RX_EMPTY_BYTE     = 8'hFF;

	// Mark the pointer values that land on the status register, one bit per value
	function automatic logic [7:0] status_slots();
		logic [7:0] slots;
		for (int p = 0; p < 8; p++)
			slots[p] = ((p % StatusRegCount) == 0);
		return slots;
	endfunction

	localparam logic [7:0] STATUS_SLOTS = status_slots();

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	// Register index, taken from paddr bit 2
	typedef enum logic {
		REG_CONSOLE_CHANNEL = 1'b0,
		REG_CONSOLE_ON      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic console_channel;
		logic console_on;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic [7:0] write_value;
		logic       register_select;
		logic       channel;
		mode_t      mode;
	} item_t;

	typedef struct packed {
		logic       rx_accepted;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic [7:0] read_data;
	} result_t;

	// Assemble the status byte: bit 0 receive available, bit 2 transmit empty
	function automatic logic [7:0] status_byte(input logic rx_avail, input logic tx_empty);
		return {5'b0, tx_empty, 1'b0, rx_avail};
	endfunction

endpackage

// ===== sv/dcsrp_cfg.sv =====
// APB configuration registers: console channel and console enable.
// Depends on dcsrp_pkg.
module dcsrp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dcsrp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [dcsrp_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [dcsrp_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	output dcsrp_pkg::cfg_t                   cfg
);

	dcsrp_pkg::cfg_t    cfg_q;
	dcsrp_pkg::reg_idx_t idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = dcsrp_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.console_channel <= 1'b0;
			cfg_q.console_on      <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				dcsrp_pkg::REG_CONSOLE_CHANNEL: cfg_q.console_channel <= pwdata[0];
				dcsrp_pkg::REG_CONSOLE_ON:      cfg_q.console_on      <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			dcsrp_pkg::REG_CONSOLE_CHANNEL: prdata[0] = cfg_q.console_channel;
			dcsrp_pkg::REG_CONSOLE_ON:      prdata[0] = cfg_q.console_on;
			default: ;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/dcsrp_core.sv =====
// Per-channel state of both serial channels and the combinational update for one
// transaction. Depends on dcsrp_pkg.
module dcsrp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  dcsrp_pkg::item_t   item,
	input  dcsrp_pkg::cfg_t    cfg,
	output dcsrp_pkg::result_t result
);

	logic [2:0] ptr_q     [2];
	logic       rx_pend_q [2];
	logic       tx_pend_q [2];
	logic       st_rx_q   [2];
	logic       st_tx_q   [2];
	logic [7:0] rx_hold_q [2];
	logic [7:0] tx_hold_q [2];

	logic [2:0] ptr_n     [2];
	logic       rx_pend_n [2];
	logic       tx_pend_n [2];
	logic       st_rx_n   [2];
	logic       st_tx_n   [2];
	logic [7:0] rx_hold_n [2];
	logic [7:0] tx_hold_n [2];

	logic       ch;
	logic       cc;
	logic       status_slot;

	assign ch          = item.channel;
	assign cc          = cfg.console_channel;
	assign status_slot = dcsrp_pkg::STATUS_SLOTS[ptr_q[ch]];

	// Compute result and next state for the transaction in stage 1
	always_comb begin
		ptr_n     = ptr_q;
		rx_pend_n = rx_pend_q;
		tx_pend_n = tx_pend_q;
		st_rx_n   = st_rx_q;
		st_tx_n   = st_tx_q;
		rx_hold_n = rx_hold_q;
		tx_hold_n = tx_hold_q;
		result    = '0;

		unique case (item.mode)
			dcsrp_pkg::MODE_READ: begin
				if (item.register_select) begin
					if (rx_pend_q[ch]) begin
						result.read_data = rx_hold_q[ch];
						rx_pend_n[ch]    = 1'b0;
						st_rx_n[ch]      = 1'b0;
					end else begin
						result.read_data = dcsrp_pkg::RX_EMPTY_BYTE;
					end
				end else begin
					if (status_slot) begin
						result.read_data = dcsrp_pkg::status_byte(st_rx_q[ch], st_tx_q[ch]);
					end
					ptr_n[ch] = 3'd0;
				end
			end
			dcsrp_pkg::MODE_WRITE: begin
				if (item.register_select) begin
					tx_hold_n[ch] = item.write_value;
					tx_pend_n[ch] = 1'b1;
					st_tx_n[ch]   = 1'b0;
				end else if (ptr_q[ch] == 3'd0) begin
					ptr_n[ch] = item.write_value[2:0];
					if (item.write_value[5:3] == dcsrp_pkg::CMD_CHANNEL_RESET) begin
						rx_pend_n[ch] = 1'b0;
						tx_pend_n[ch] = 1'b0;
						st_rx_n[ch]   = 1'b0;
						st_tx_n[ch]   = 1'b1;
					end
				end else begin
					ptr_n[ch] = 3'd0;
				end
			end
			dcsrp_pkg::MODE_TICK: begin
				// Drain transmits; only the console channel goes out, and only while console_on is set
				for (int c = 0; c < 2; c++) begin
					if (tx_pend_q[c]) begin
						if (1'(c) == cc && cfg.console_on) begin
							result.tx_valid = 1'b1;
							result.tx_byte  = tx_hold_q[c];
						end
						tx_pend_n[c] = 1'b0;
						st_tx_n[c]   = 1'b1;
					end
				end
				// Take the offered byte into the console channel
				if (cfg.console_on && !rx_pend_q[cc] && item.rx_valid) begin
					rx_hold_n[cc]      = item.rx_byte;
					rx_pend_n[cc]      = 1'b1;
					st_rx_n[cc]        = 1'b1;
					result.rx_accepted = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control and status state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				ptr_q[c]     <= 3'd0;
				rx_pend_q[c] <= 1'b0;
				tx_pend_q[c] <= 1'b0;
				st_rx_q[c]   <= 1'b0;
				st_tx_q[c]   <= 1'b1;
			end
		end else if (advance) begin
			ptr_q     <= ptr_n;
			rx_pend_q <= rx_pend_n;
			tx_pend_q <= tx_pend_n;
			st_rx_q   <= st_rx_n;
			st_tx_q   <= st_tx_n;
		end
	end

	// Holding bytes are read only while their pending flag is set
	always_ff @(posedge clk) begin
		if (advance) begin
			rx_hold_q <= rx_hold_n;
			tx_hold_q <= tx_hold_n;
		end
	end

endmodule

// ===== sv/dual_channel_serial_register_port.sv =====
// Top level of the dual channel serial register port: input stage, channel core,
// result register and APB configuration. Depends on dcsrp_pkg, dcsrp_cfg, dcsrp_core.

// Each stream transaction is a register read, a register write or a time tick
// aimed at one of two serial channels. The block takes one transaction per
// clock while the output side is not stalled and returns exactly one result
// transaction for each, through the input register and the result register.
// The rate is set by the channel state update, which reads and rewrites the
// pointer, status and holding registers of both channels between the input
// register and the result register. The result register lets a new transaction
// enter while a finished result waits on m_tready. Write configuration
// (console channel at 0x0, console enable at 0x4) only while no transaction is
// in flight.
module dual_channel_serial_register_port (
	input  logic                              clk,
	input  logic                              arst_n,
	// Stream in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] write_value, [8] rx_valid, [16:9] rx_byte, [23:17] zero
	input  logic [dcsrp_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] mode, [2] channel, [3] register_select
	input  logic [dcsrp_pkg::IN_USER_W-1:0]   s_tuser,
	// Stream out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] rx_accepted, [23:18] zero
	output logic [dcsrp_pkg::OUT_DATA_W-1:0]  m_tdata,
	// APB configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dcsrp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [dcsrp_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [dcsrp_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready
);

	dcsrp_pkg::cfg_t    cfg;
	dcsrp_pkg::item_t   item_in;
	dcsrp_pkg::item_t   item_s1;
	dcsrp_pkg::result_t result;
	dcsrp_pkg::result_t result_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               out_free;
	logic               advance;

	dcsrp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Unpack the incoming transaction
	always_comb begin
		item_in.mode            = dcsrp_pkg::mode_t'(s_tuser[1:0]);
		item_in.channel         = s_tuser[2];
		item_in.register_select = s_tuser[3];
		item_in.write_value     = s_tdata[7:0];
		item_in.rx_valid        = s_tdata[8];
		item_in.rx_byte         = s_tdata[16:9];
	end

	// Handshake: stage 1 moves on whenever the result register is free
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	dcsrp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, result_s2.rx_accepted, result_s2.tx_byte,
		result_s2.tx_valid, result_s2.read_data};

	// A result appears only after stage 1 held a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 ##1 valid_s2 |-> $past(valid_s1))
		else $error("result valid without a transaction in stage 1");

	// Tick results never carry read data
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (result_s2.tx_valid || result_s2.rx_accepted)
		|-> result_s2.read_data == 8'd0)
		else $error("tick result carries read data");

	// Input stalls only when both stages are full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule
